// ===== rtl/core/cnlc_pkg.sv =====
package cnlc_pkg;

    localparam int BIN_W     = 64;
    localparam int NUM_DIGITS = 20;
    localparam int BCD_W     = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W = $clog2(BIN_W);
    localparam int COUNT_W   = 5;

    localparam logic [1:0] CLASS_INVALID = 2'd0;
    localparam logic [1:0] CLASS_LEAD4   = 2'd1;
    localparam logic [1:0] CLASS_P34_37  = 2'd2;
    localparam logic [1:0] CLASS_P51_55  = 2'd3;

    localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
    localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
    localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan_step;
    } cnlc_cmd_t;

    typedef struct packed {
        logic last_digit;
    } cnlc_status_t;

endpackage

// ===== rtl/core/cnlc_ctrl.sv =====
module cnlc_ctrl
    import cnlc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  cnlc_status_t status,
    output cnlc_cmd_t    cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t               state_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg   <= ST_CONV;
                        bit_cnt_reg <= '0;
                        busy_reg    <= 1'b1;
                    end
                end
                ST_CONV:
                begin
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == BIT_CNT_W'(BIN_W - 1))
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (status.last_digit)
                    begin
                        state_reg <= ST_DONE;
                        done_reg  <= 1'b1;
                    end
                end
                ST_DONE:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b0;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    done_reg  <= 1'b0;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.load      = (state_reg == ST_IDLE) && start;
        cmd.conv_step = (state_reg == ST_CONV);
        cmd.scan_step = (state_reg == ST_SCAN);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ===== rtl/core/cnlc_datapath.sv =====
module cnlc_datapath
    import cnlc_pkg::*;
(
    input  logic               clk,
    input  cnlc_cmd_t          cmd,
    input  logic [BIN_W-1:0]   card_number,
    output cnlc_status_t       status,
    output logic [1:0]         card_class,
    output logic [COUNT_W-1:0] digit_count,
    output logic               checksum_ok
);

    logic [BIN_W-1:0]   bin_reg;
    logic [BCD_W-1:0]   bcd_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [3:0]         sum_reg;
    logic [3:0]         top_reg;
    logic [3:0]         second_reg;

    logic [BCD_W-1:0]   bcd_adj;
    logic [3:0]         digit;
    logic [4:0]         dbl;
    logic [3:0]         term;
    logic [4:0]         sum_raw;
    logic [3:0]         sum_next;

    // add three to every digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        digit = bcd_reg[3:0];
        dbl   = {digit, 1'b0};
        if (!count_reg[0])
        begin
            term = digit;
        end
        else if (dbl > 5'd9)
        begin
            term = 4'(dbl - 5'd9);
        end
        else
        begin
            term = dbl[3:0];
        end
        sum_raw = {1'b0, sum_reg} + {1'b0, term};
        if (sum_raw >= 5'd10)
        begin
            sum_next = 4'(sum_raw - 5'd10);
        end
        else
        begin
            sum_next = sum_raw[3:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg    <= card_number;
            bcd_reg    <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
            top_reg    <= '0;
            second_reg <= '0;
        end
        else if (cmd.conv_step)
        begin
            {bcd_reg, bin_reg} <= {bcd_adj[BCD_W-2:0], bin_reg, 1'b0};
        end
        else if (cmd.scan_step)
        begin
            bcd_reg    <= {4'd0, bcd_reg[BCD_W-1:4]};
            count_reg  <= count_reg + 1'b1;
            sum_reg    <= sum_next;
            top_reg    <= digit;
            second_reg <= top_reg;
        end
    end

    assign status.last_digit = (bcd_reg[BCD_W-1:4] == '0);

    always_comb
    begin
        card_class = CLASS_INVALID;
        if ((count_reg == LEN_13 || count_reg == LEN_16) && top_reg == 4'd4)
        begin
            card_class = CLASS_LEAD4;
        end
        else if (count_reg == LEN_15 && top_reg == 4'd3
                 && (second_reg == 4'd4 || second_reg == 4'd7))
        begin
            card_class = CLASS_P34_37;
        end
        else if (count_reg == LEN_16 && top_reg == 4'd5
                 && second_reg >= 4'd1 && second_reg <= 4'd5)
        begin
            card_class = CLASS_P51_55;
        end
    end

    assign digit_count = count_reg;
    assign checksum_ok = (sum_reg == 4'd0);

endmodule

// ===== rtl/core/card_number_luhn_classifier.sv =====
// Sequence: after the accepting edge the binary card number is converted to BCD, one bit a
// cycle, then its N digits (N the digit count, 1 to 20) are scanned one digit a cycle; then done rises.
// A new card number is taken only when idle; busy stays high until the strobe cycle has passed.
// The results are valid for the single cycle in which done is high; the receiver cannot stall.
// Reset: rst_n, asynchronous and active low, returns the controller to idle with busy and
// done low.
module card_number_luhn_classifier
    import cnlc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [BIN_W-1:0]   card_number,
    output logic               busy,
    output logic               done,
    output logic [1:0]         card_class,
    output logic [COUNT_W-1:0] digit_count,
    output logic               checksum_ok
);

    cnlc_cmd_t    cmd;
    cnlc_status_t status;

    cnlc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    cnlc_datapath u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .card_number (card_number),
        .status      (status),
        .card_class  (card_class),
        .digit_count (digit_count),
        .checksum_ok (checksum_ok)
    );

endmodule
